// File: rtl/core/sct_pkg.sv
// Package for the source code tokenizer: token kinds, character codes,
// and the decode functions shared by the scanner. No dependencies.
`default_nettype none
package sct_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int LINE_BITS       = 24;
    localparam int KIND_BITS       = 6;
    localparam int CAUSE_BITS      = 2;
    localparam int QDEPTH          = 4;

    localparam logic [KIND_BITS-1:0] K_END      = 6'd0;
    localparam logic [KIND_BITS-1:0] K_STRING   = 6'd1;
    localparam logic [KIND_BITS-1:0] K_INTEGER  = 6'd2;
    localparam logic [KIND_BITS-1:0] K_DECIMAL  = 6'd3;
    localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd4;
    localparam logic [KIND_BITS-1:0] K_AS       = 6'd5;
    localparam logic [KIND_BITS-1:0] K_FN       = 6'd6;
    localparam logic [KIND_BITS-1:0] K_IF       = 6'd7;
    localparam logic [KIND_BITS-1:0] K_LET      = 6'd8;
    localparam logic [KIND_BITS-1:0] K_INT      = 6'd9;
    localparam logic [KIND_BITS-1:0] K_ELSE     = 6'd10;
    localparam logic [KIND_BITS-1:0] K_UINT     = 6'd11;
    localparam logic [KIND_BITS-1:0] K_VOID     = 6'd12;
    localparam logic [KIND_BITS-1:0] K_CHAR     = 6'd13;
    localparam logic [KIND_BITS-1:0] K_WHILE    = 6'd14;
    localparam logic [KIND_BITS-1:0] K_BREAK    = 6'd15;
    localparam logic [KIND_BITS-1:0] K_CONST    = 6'd16;
    localparam logic [KIND_BITS-1:0] K_FLOAT    = 6'd17;
    localparam logic [KIND_BITS-1:0] K_STRUCT   = 6'd18;
    localparam logic [KIND_BITS-1:0] K_RETURN   = 6'd19;
    localparam logic [KIND_BITS-1:0] K_EXTERN   = 6'd20;
    localparam logic [KIND_BITS-1:0] K_TYPEDEF  = 6'd21;
    localparam logic [KIND_BITS-1:0] K_CONTINUE = 6'd22;
    localparam logic [KIND_BITS-1:0] K_DOT      = 6'd23;
    localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd24;
    localparam logic [KIND_BITS-1:0] K_COLON    = 6'd25;
    localparam logic [KIND_BITS-1:0] K_EQEQ     = 6'd26;
    localparam logic [KIND_BITS-1:0] K_ASSIGN   = 6'd27;
    localparam logic [KIND_BITS-1:0] K_ARROW    = 6'd28;
    localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd29;
    localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd30;
    localparam logic [KIND_BITS-1:0] K_STAR     = 6'd31;
    localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd32;
    localparam logic [KIND_BITS-1:0] K_PERCENT  = 6'd33;
    localparam logic [KIND_BITS-1:0] K_CARET    = 6'd34;
    localparam logic [KIND_BITS-1:0] K_TILDE    = 6'd35;
    localparam logic [KIND_BITS-1:0] K_NE       = 6'd36;
    localparam logic [KIND_BITS-1:0] K_BANG     = 6'd37;
    localparam logic [KIND_BITS-1:0] K_ANDAND   = 6'd38;
    localparam logic [KIND_BITS-1:0] K_AMP      = 6'd39;
    localparam logic [KIND_BITS-1:0] K_OROR     = 6'd40;
    localparam logic [KIND_BITS-1:0] K_BAR      = 6'd41;
    localparam logic [KIND_BITS-1:0] K_SHR      = 6'd42;
    localparam logic [KIND_BITS-1:0] K_GE       = 6'd43;
    localparam logic [KIND_BITS-1:0] K_GT       = 6'd44;
    localparam logic [KIND_BITS-1:0] K_SHL      = 6'd45;
    localparam logic [KIND_BITS-1:0] K_LE       = 6'd46;
    localparam logic [KIND_BITS-1:0] K_LT       = 6'd47;
    localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd48;
    localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd49;
    localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd50;
    localparam logic [KIND_BITS-1:0] K_LBRACK   = 6'd51;
    localparam logic [KIND_BITS-1:0] K_RBRACK   = 6'd52;
    localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd53;
    localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd54;

    localparam logic [CAUSE_BITS-1:0] C_NONE    = 2'd0;
    localparam logic [CAUSE_BITS-1:0] C_UNKNOWN = 2'd1;
    localparam logic [CAUSE_BITS-1:0] C_POINT   = 2'd2;
    localparam logic [CAUSE_BITS-1:0] C_UNTERM  = 2'd3;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [6:0] {
        SC_IDLE    = 7'b0000001,
        SC_OP2     = 7'b0000010,
        SC_COMMENT = 7'b0000100,
        SC_STRING  = 7'b0001000,
        SC_NUMBER  = 7'b0010000,
        SC_WORD    = 7'b0100000,
        SC_DONE    = 7'b1000000
    } scan_t;

    typedef struct packed {
        logic       done;
        logic [1:0] push_n;
    } fe_stat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == CH_NL || c == 8'h0B || c == 8'h0C
            || c == 8'h0D;
    endfunction

    // zero means no single-character token
    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        k = K_END;
        case (c)
            ".": k = K_DOT;     ";": k = K_SEMI;    ":": k = K_COLON;
            "+": k = K_PLUS;    "*": k = K_STAR;    "%": k = K_PERCENT;
            "^": k = K_CARET;   "~": k = K_TILDE;   ",": k = K_COMMA;
            "(": k = K_LPAREN;  ")": k = K_RPAREN;  "[": k = K_LBRACK;
            "]": k = K_RBRACK;  "{": k = K_LBRACE;  "}": k = K_RBRACE;
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_BITS-1:0] lead_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        k = K_END;
        case (c)
            "=": k = K_ASSIGN;  "-": k = K_MINUS;   "!": k = K_BANG;
            "&": k = K_AMP;     "|": k = K_BAR;     ">": k = K_GT;
            "<": k = K_LT;      "/": k = K_SLASH;
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_BITS-1:0] pair_kind(input logic [7:0] h,
                                                       input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        k = K_END;
        if (h == "=" && c == "=") k = K_EQEQ;
        else if (h == "-" && c == ">") k = K_ARROW;
        else if (h == "!" && c == "=") k = K_NE;
        else if (h == "&" && c == "&") k = K_ANDAND;
        else if (h == "|" && c == "|") k = K_OROR;
        else if (h == ">" && c == ">") k = K_SHR;
        else if (h == ">" && c == "=") k = K_GE;
        else if (h == "<" && c == "<") k = K_SHL;
        else if (h == "<" && c == "=") k = K_LE;
        return k;
    endfunction

    // prefix holds the first bytes of the word, first byte lowest
    function automatic logic [KIND_BITS-1:0] word_kind(input logic [63:0] p,
                                                       input logic [3:0] wl);
        logic [KIND_BITS-1:0] k;
        k = K_IDENT;
        if (wl == 4'd2 && p == {48'h0, "sa"}) k = K_AS;
        else if (wl == 4'd2 && p == {48'h0, "nf"}) k = K_FN;
        else if (wl == 4'd2 && p == {48'h0, "fi"}) k = K_IF;
        else if (wl == 4'd3 && p == {40'h0, "tel"}) k = K_LET;
        else if (wl == 4'd3 && p == {40'h0, "tni"}) k = K_INT;
        else if (wl == 4'd4 && p == {32'h0, "esle"}) k = K_ELSE;
        else if (wl == 4'd4 && p == {32'h0, "tniu"}) k = K_UINT;
        else if (wl == 4'd4 && p == {32'h0, "diov"}) k = K_VOID;
        else if (wl == 4'd4 && p == {32'h0, "rahc"}) k = K_CHAR;
        else if (wl == 4'd5 && p == {24'h0, "elihw"}) k = K_WHILE;
        else if (wl == 4'd5 && p == {24'h0, "kaerb"}) k = K_BREAK;
        else if (wl == 4'd5 && p == {24'h0, "tsnoc"}) k = K_CONST;
        else if (wl == 4'd5 && p == {24'h0, "taolf"}) k = K_FLOAT;
        else if (wl == 4'd6 && p == {16'h0, "tcurts"}) k = K_STRUCT;
        else if (wl == 4'd6 && p == {16'h0, "nruter"}) k = K_RETURN;
        else if (wl == 4'd6 && p == {16'h0, "nretxe"}) k = K_EXTERN;
        else if (wl == 4'd7 && p == {8'h0, "fedepyt"}) k = K_TYPEDEF;
        else if (wl == 4'd8 && p == "eunitnoc") k = K_CONTINUE;
        return k;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/source_code_tokenizer.sv
// Top level of the source code tokenizer: scanner, token queue, output stage.
// Depends on sct_pkg, sct_front, sct_queue, sct_back.
//
// channel   dir  word                                  last/user
// s_axis    in   ch[7:0]                               none
// m_axis    out  kind,start,length,line,error_cause    none
//
// One byte per cycle while s_tready is high; a byte that closes a token and is itself a one-byte token gives two words.
// Input stalls only while the four-entry token queue has under two free places.
// Output word is registered; each word passes through the token queue into the output register.
// Reset returns the scan state to idle, clears the offset, sets the line count to one and empties the queue.
`default_nettype none
module source_code_tokenizer
    import sct_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int TW = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS + CAUSE_BITS,
    parameter int DW = ((TW + 7) / 8) * 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // ch
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [DW-1:0]      m_tdata    // kind, start, length, line, error_cause
);

    fe_stat_t                      stat;
    logic [TW-1:0]                 tok_a, tok_b, q_data;
    logic                          q_valid, q_pop, space;
    logic [$clog2(QDEPTH+1)-1:0]   level;

    assign s_tready = space;

    sct_front #(
        .OFFSET_BITS(OFFSET_BITS),
        .LENGTH_BITS(LENGTH_BITS),
        .TW(TW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_tvalid && s_tready),
        .ch(s_tdata),
        .stat(stat),
        .tok_a(tok_a),
        .tok_b(tok_b)
    );

    sct_queue #(
        .TW(TW)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .stat(stat),
        .wr_a(tok_a),
        .wr_b(tok_b),
        .pop(q_pop),
        .space(space),
        .not_empty(q_valid),
        .rd_data(q_data),
        .level(level)
    );

    sct_back #(
        .TW(TW),
        .DW(DW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_data(q_data),
        .q_pop(q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        level <= ($clog2(QDEPTH+1))'(QDEPTH))
        else $error("queue overfilled");

    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> stat.push_n == 2'd0)
        else $error("word after end");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> level <= ($clog2(QDEPTH+1))'(QDEPTH - 2))
        else $error("ready without room");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> stat.done)
        else $error("left end state");

endmodule
`default_nettype wire

// File: rtl/core/sct_front.sv
// Scanner front end: takes one byte a cycle while in_valid is high, tracks offset and line,
// and produces up to two packed tokens per byte. Depends on sct_pkg.
`default_nettype none
module sct_front
    import sct_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int TW = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS + CAUSE_BITS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    ch,
    output fe_stat_t           stat,
    output logic [TW-1:0]      tok_a,
    output logic [TW-1:0]      tok_b
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_TWO  = LENGTH_BITS'(2);

    scan_t                   state_reg, state_next;
    logic [7:0]              held_reg, held_next;
    logic [OFFSET_BITS-1:0]  tstart_reg, tstart_next;
    logic [LENGTH_BITS-1:0]  tlen_reg, tlen_next;
    logic [LINE_BITS-1:0]    tline_reg, tline_next;
    logic [OFFSET_BITS-1:0]  off_reg;
    logic [LINE_BITS-1:0]    line_reg, line_next;
    logic [63:0]             prefix_reg, prefix_next;
    logic                    dec_reg, dec_next;

    logic [KIND_BITS-1:0] sk, lk, hk, pk;
    logic [3:0]           wl;
    logic                 st_emit, st_open, st_word, st_nl;
    scan_t                st_state;
    logic [LENGTH_BITS-1:0] st_len;
    logic [TW-1:0]        st_tok, tok0, tok1;
    logic                 v0, v1, use_start;
    logic [LENGTH_BITS-1:0] grown;

    function automatic logic [TW-1:0] mk(input logic [KIND_BITS-1:0] k,
                                         input logic [OFFSET_BITS-1:0] s,
                                         input logic [LENGTH_BITS-1:0] l,
                                         input logic [LINE_BITS-1:0] ln,
                                         input logic [CAUSE_BITS-1:0] cs);
        return {cs, ln, l, s, k};
    endfunction

    assign sk = single_kind(ch);
    assign lk = lead_kind(ch);
    assign hk = lead_kind(held_reg);
    assign pk = pair_kind(held_reg, ch);
    assign wl = (tlen_reg > LENGTH_BITS'(8)) ? 4'd15 : tlen_reg[3:0];
    assign grown = (tlen_reg != LEN_MAX) ? tlen_reg + LEN_ONE : tlen_reg;

    // what a byte does when no token is open
    always_comb
    begin
        st_emit  = 1'b0;
        st_open  = 1'b0;
        st_word  = 1'b0;
        st_nl    = 1'b0;
        st_state = SC_IDLE;
        st_len   = LEN_ONE;
        st_tok   = mk(K_END, off_reg, LEN_ONE, line_reg, C_NONE);
        if (ch == CH_NUL)
        begin
            st_emit  = 1'b1;
            st_state = SC_DONE;
        end
        else if (is_blank(ch))
        begin
            st_nl = (ch == CH_NL);
        end
        else if (sk != K_END)
        begin
            st_emit = 1'b1;
            st_tok  = mk(sk, off_reg, LEN_ONE, line_reg, C_NONE);
        end
        else if (lk != K_END)
        begin
            st_open  = 1'b1;
            st_state = SC_OP2;
        end
        else if (ch == CH_QUOTE)
        begin
            st_open  = 1'b1;
            st_len   = '0;
            st_state = SC_STRING;
        end
        else if (is_digit(ch))
        begin
            st_open  = 1'b1;
            st_state = SC_NUMBER;
        end
        else if (is_alpha(ch) || ch == CH_USCORE)
        begin
            st_open  = 1'b1;
            st_word  = 1'b1;
            st_state = SC_WORD;
        end
        else
        begin
            st_emit  = 1'b1;
            st_state = SC_DONE;
            st_tok   = mk(K_END, off_reg, LEN_ONE, line_reg, C_UNKNOWN);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        tline_next  = tline_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        dec_next    = dec_reg;
        use_start   = 1'b0;
        v0          = 1'b0;
        v1          = 1'b0;
        tok0        = mk(K_END, tstart_reg, tlen_reg, tline_reg, C_NONE);
        tok1        = st_tok;
        unique case (state_reg)
            SC_IDLE:
            begin
                use_start = 1'b1;
            end
            SC_OP2:
            begin
                if (held_reg == CH_SLASH && ch == CH_SLASH)
                    state_next = SC_COMMENT;
                else if (pk != K_END)
                begin
                    v0         = 1'b1;
                    tok0       = mk(pk, tstart_reg, LEN_TWO, tline_reg, C_NONE);
                    state_next = SC_IDLE;
                end
                else
                begin
                    v0        = 1'b1;
                    tok0      = mk(hk, tstart_reg, LEN_ONE, tline_reg, C_NONE);
                    use_start = 1'b1;
                end
            end
            SC_COMMENT:
            begin
                if (ch == CH_NUL || ch == CH_NL)
                    use_start = 1'b1;
            end
            SC_STRING:
            begin
                if (ch == CH_QUOTE)
                begin
                    v0         = 1'b1;
                    tok0       = mk(K_STRING, tstart_reg, tlen_reg, tline_reg, C_NONE);
                    state_next = SC_IDLE;
                end
                else if (ch == CH_NUL)
                begin
                    v0         = 1'b1;
                    tok0       = mk(K_END, tstart_reg, LEN_ONE, tline_reg, C_UNTERM);
                    state_next = SC_DONE;
                end
                else
                    tlen_next = grown;
            end
            SC_NUMBER:
            begin
                if (is_digit(ch))
                    tlen_next = grown;
                else if (ch == CH_DOT)
                begin
                    if (dec_reg)
                    begin
                        v0         = 1'b1;
                        tok0       = mk(K_END, tstart_reg, tlen_reg, tline_reg, C_POINT);
                        state_next = SC_DONE;
                    end
                    else
                    begin
                        dec_next  = 1'b1;
                        tlen_next = grown;
                    end
                end
                else
                begin
                    v0        = 1'b1;
                    tok0      = mk(dec_reg ? K_DECIMAL : K_INTEGER, tstart_reg, tlen_reg,
                                   tline_reg, C_NONE);
                    use_start = 1'b1;
                end
            end
            SC_WORD:
            begin
                if (is_digit(ch) || is_alpha(ch) || ch == CH_USCORE)
                begin
                    if (tlen_reg < LENGTH_BITS'(8))
                        prefix_next = prefix_reg | ({56'h0, ch} << {tlen_reg[2:0], 3'b000});
                    tlen_next = grown;
                end
                else
                begin
                    v0        = 1'b1;
                    tok0      = mk(word_kind(prefix_reg, wl), tstart_reg, tlen_reg,
                                   tline_reg, C_NONE);
                    use_start = 1'b1;
                end
            end
            SC_DONE:
            begin
                state_next = SC_DONE;
            end
            default:
            begin
                state_next = SC_DONE;
            end
        endcase
        if (use_start)
        begin
            state_next = st_state;
            v1         = st_emit;
            if (st_open)
            begin
                held_next   = ch;
                tstart_next = off_reg;
                tline_next  = line_reg;
                tlen_next   = st_len;
                dec_next    = 1'b0;
                if (st_word)
                    prefix_next = {56'h0, ch};
            end
            if (st_nl && line_reg != LINE_MAX)
                line_next = line_reg + LINE_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SC_IDLE;
            held_reg   <= '0;
            tstart_reg <= '0;
            tlen_reg   <= '0;
            tline_reg  <= LINE_BITS'(1);
            off_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            prefix_reg <= '0;
            dec_reg    <= 1'b0;
        end
        else if (in_valid)
        begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            tstart_reg <= tstart_next;
            tlen_reg   <= tlen_next;
            tline_reg  <= tline_next;
            off_reg    <= off_reg + OFFSET_BITS'(1);
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            dec_reg    <= dec_next;
        end
    end

    assign tok_a       = v0 ? tok0 : tok1;
    assign tok_b       = tok1;
    assign stat.done   = (state_reg == SC_DONE);
    assign stat.push_n = in_valid ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;

endmodule
`default_nettype wire

// File: rtl/core/sct_queue.sv
// Token queue between scanner and output stage: two writes, one read per
// cycle. Depends on sct_pkg.
`default_nettype none
module sct_queue
    import sct_pkg::*;
#(
    parameter int TW = 72
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fe_stat_t                   stat,
    input  wire logic [TW-1:0]              wr_a,
    input  wire logic [TW-1:0]              wr_b,
    input  wire logic                       pop,
    output logic                            space,
    output logic                            not_empty,
    output logic [TW-1:0]                   rd_data,
    output logic [$clog2(QDEPTH+1)-1:0]     level
);

    localparam int PW = $clog2(QDEPTH);
    localparam int LW = $clog2(QDEPTH+1);

    logic [TW-1:0] mem_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [LW-1:0] cnt_reg;
    logic          do_pop;

    assign do_pop    = pop && (cnt_reg != '0);
    assign not_empty = (cnt_reg != '0);
    assign space     = (cnt_reg <= LW'(QDEPTH - 2));
    assign rd_data   = mem_reg[rp_reg];
    assign level     = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (stat.push_n != 2'd0)
            mem_reg[wp_reg] <= wr_a;
        if (stat.push_n == 2'd2)
            mem_reg[wp_reg + PW'(1)] <= wr_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + PW'(stat.push_n);
            if (do_pop)
                rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + LW'(stat.push_n) - LW'(do_pop);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sct_back.sv
// Output stage: registers one token word from the queue and holds it
// until the sink takes it. Depends on sct_pkg.
`default_nettype none
module sct_back
    import sct_pkg::*;
#(
    parameter int TW = 72,
    parameter int DW = 72
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire logic [TW-1:0] q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [DW-1:0]      m_tdata
);

    logic          valid_reg;
    logic [DW-1:0] data_reg;

    assign q_pop    = q_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || m_tready)
            valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= DW'(q_data);
    end

endmodule
`default_nettype wire

// File: tb/sct_token_checker.sv
// Token checker for the source code tokenizer: watches both stream channels,
// predicts the token words from the accepted bytes and compares them in order.
// Depends on sct_pkg for token kinds and error causes.
`timescale 1ns / 100ps
module sct_token_checker
    import sct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,
    output int               errors,
    output int               pending
);

    typedef enum {LX_IDLE, LX_OP2, LX_COMMENT, LX_STRING, LX_NUMBER, LX_WORD, LX_DONE} lex_t;

    typedef struct {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [15:0] len;
        logic [23:0] line;
        logic [1:0]  cause;
    } token_t;

    token_t      tokens_due[$];
    lex_t        lx;
    logic [7:0]  held;
    logic [23:0] tok_start;
    logic [15:0] tok_len;
    logic [23:0] tok_line;
    logic [23:0] offs;
    logic [23:0] lines;
    logic [63:0] prefix;
    logic [5:0]  num_kind;

    string kw_names [18] = '{"as", "fn", "if", "let", "int", "else", "uint", "void", "char",
                             "while", "break", "const", "float", "struct", "return",
                             "extern", "typedef", "continue"};

    task automatic report(input string msg);
        $display("token check: %s", msg);
        errors++;
    endtask

    task automatic put(input logic [5:0] k, input logic [23:0] s, input logic [15:0] l,
                       input logic [23:0] ln, input logic [1:0] c);
        token_t t;
        t.kind = k;
        t.start = s;
        t.len = l;
        t.line = ln;
        t.cause = c;
        tokens_due.push_back(t);
    endtask

    function automatic logic [5:0] op_single(input logic [7:0] c);
        case (c)
            ".": return K_DOT;      ";": return K_SEMI;     ":": return K_COLON;
            "+": return K_PLUS;     "*": return K_STAR;     "%": return K_PERCENT;
            "^": return K_CARET;    "~": return K_TILDE;    ",": return K_COMMA;
            "(": return K_LPAREN;   ")": return K_RPAREN;   "[": return K_LBRACK;
            "]": return K_RBRACK;   "{": return K_LBRACE;   "}": return K_RBRACE;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [5:0] op_lead(input logic [7:0] c);
        case (c)
            "=": return K_ASSIGN;   "-": return K_MINUS;    "!": return K_BANG;
            "&": return K_AMP;      "|": return K_BAR;      ">": return K_GT;
            "<": return K_LT;       "/": return K_SLASH;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [5:0] op_pair(input logic [7:0] h, input logic [7:0] c);
        case ({h, c})
            "==": return K_EQEQ;    "->": return K_ARROW;   "!=": return K_NE;
            "&&": return K_ANDAND;  "||": return K_OROR;    ">>": return K_SHR;
            ">=": return K_GE;      "<<": return K_SHL;     "<=": return K_LE;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [5:0] word_class();
        logic [63:0] packed_kw;
        for (int i = 0; i < 18; i++)
        begin
            if (tok_len == 16'(kw_names[i].len()))
            begin
                packed_kw = '0;
                for (int j = 0; j < kw_names[i].len(); j++)
                    packed_kw |= 64'(kw_names[i][j]) << (8 * j);
                if (packed_kw == prefix)
                    return 6'(K_AS + i);
            end
        end
        return K_IDENT;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    task automatic open_tok(input logic [15:0] l);
        tok_start = offs;
        tok_line = lines;
        tok_len = l;
    endtask

    task automatic grow();
        if (tok_len != 16'hFFFF)
            tok_len++;
    endtask

    task automatic begin_tok(input logic [7:0] c);
        if (c == 8'h00)
        begin
            lx = LX_DONE;
            put(K_END, offs, 1, lines, C_NONE);
        end
        else if (c == " " || (c >= 8'h09 && c <= 8'h0D))
        begin
            if (c == 8'h0A && lines != 24'hFFFFFF)
                lines++;
        end
        else if (op_single(c) != K_END)
            put(op_single(c), offs, 1, lines, C_NONE);
        else if (op_lead(c) != K_END)
        begin
            held = c;
            open_tok(1);
            lx = LX_OP2;
        end
        else if (c == 8'h22)
        begin
            open_tok(0);
            lx = LX_STRING;
        end
        else if (is_num(c))
        begin
            open_tok(1);
            num_kind = K_INTEGER;
            lx = LX_NUMBER;
        end
        else if (is_letter(c))
        begin
            open_tok(1);
            prefix = 64'(c);
            lx = LX_WORD;
        end
        else
        begin
            lx = LX_DONE;
            put(K_END, offs, 1, lines, C_UNKNOWN);
        end
    endtask

    task automatic lex_byte(input logic [7:0] c);
        if (lx == LX_DONE)
            return;
        case (lx)
            LX_OP2:
            begin
                lx = LX_IDLE;
                if (held == "/" && c == "/")
                    lx = LX_COMMENT;
                else if (op_pair(held, c) != K_END)
                    put(op_pair(held, c), tok_start, 2, tok_line, C_NONE);
                else
                begin
                    put(op_lead(held), tok_start, 1, tok_line, C_NONE);
                    begin_tok(c);
                end
            end
            LX_COMMENT:
                if (c == 8'h00 || c == 8'h0A)
                begin
                    lx = LX_IDLE;
                    begin_tok(c);
                end
            LX_STRING:
                if (c == 8'h22)
                begin
                    lx = LX_IDLE;
                    put(K_STRING, tok_start, tok_len, tok_line, C_NONE);
                end
                else if (c == 8'h00)
                begin
                    lx = LX_DONE;
                    put(K_END, tok_start, 1, tok_line, C_UNTERM);
                end
                else
                    grow();
            LX_NUMBER:
                if (is_num(c))
                    grow();
                else if (c == ".")
                begin
                    if (num_kind == K_DECIMAL)
                    begin
                        lx = LX_DONE;
                        put(K_END, tok_start, tok_len, tok_line, C_POINT);
                    end
                    else
                    begin
                        num_kind = K_DECIMAL;
                        grow();
                    end
                end
                else
                begin
                    lx = LX_IDLE;
                    put(num_kind, tok_start, tok_len, tok_line, C_NONE);
                    begin_tok(c);
                end
            LX_WORD:
                if (is_letter(c) || is_num(c))
                begin
                    if (tok_len < 8)
                        prefix |= 64'(c) << (8 * tok_len);
                    grow();
                end
                else
                begin
                    lx = LX_IDLE;
                    put(word_class(), tok_start, tok_len, tok_line, C_NONE);
                    begin_tok(c);
                end
            default:
                begin_tok(c);
        endcase
        offs++;
    endtask

    task automatic check_word(input logic [71:0] w);
        token_t t;
        if (tokens_due.size() == 0)
        begin
            report($sformatf("unexpected word %h", w));
            return;
        end
        t = tokens_due.pop_front();
        if (w[5:0] != t.kind)
            report($sformatf("kind %0d, predicted %0d", w[5:0], t.kind));
        if (w[29:6] != t.start)
            report($sformatf("start %0d, predicted %0d", w[29:6], t.start));
        if (w[45:30] != t.len)
            report($sformatf("length %0d, predicted %0d", w[45:30], t.len));
        if (w[69:46] != t.line)
            report($sformatf("line %0d, predicted %0d", w[69:46], t.line));
        if (w[71:70] != t.cause)
            report($sformatf("cause %0d, predicted %0d", w[71:70], t.cause));
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tokens_due.delete();
            lx = LX_IDLE;
            held = '0;
            tok_start = '0;
            tok_len = '0;
            tok_line = 24'd1;
            offs = '0;
            lines = 24'd1;
            prefix = '0;
            num_kind = K_END;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_word(m_tdata);
            if (s_tvalid && s_tready)
                lex_byte(s_tdata);
        end
        pending = tokens_due.size();
    end

endmodule

// File: tb/tb_source_code_tokenizer.sv
// Testbench top for the source code tokenizer: builds a random source text,
// streams it in under varying back-pressure and gives the verdict.
// Depends on sct_pkg, source_code_tokenizer and sct_token_checker.
`timescale 1ns / 100ps
module tb_source_code_tokenizer;
    import sct_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    int          errors;
    int          pending;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic [7:0]  text[$];

    string kw_names [18] = '{"as", "fn", "if", "let", "int", "else", "uint", "void", "char",
                             "while", "break", "const", "float", "struct", "return",
                             "extern", "typedef", "continue"};
    string singles = ".;:+*%^~,()[]{}";
    string leads = "=-!&|><";
    string pairs [9] = '{"==", "->", "!=", "&&", "||", ">>", ">=", "<<", "<="};
    string seps = ";:+*%^~,()[]{}";
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    source_code_tokenizer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sct_token_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    task automatic add(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        for (int i = 0; i < n; i++)
            text.push_back(8'($urandom_range("0", "9")));
    endtask

    task automatic add_fragment();
        int n;
        logic [7:0] b;
        case ($urandom_range(9))
            0: add(kw_names[$urandom_range(17)]);
            1:
            begin
                n = $urandom_range(1, 12);
                text.push_back(word_chars[$urandom_range(52)]);
                for (int i = 1; i < n; i++)
                    text.push_back(word_chars[$urandom_range(62)]);
            end
            2: add_digits($urandom_range(1, 6));
            3:
            begin
                add_digits($urandom_range(1, 4));
                add(".");
                add_digits($urandom_range(0, 4));
            end
            4:
            begin
                add("\"");
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                begin
                    do b = 8'($urandom_range(1, 255)); while (b == 8'h22);
                    text.push_back(b);
                end
                add("\"");
            end
            5:
            begin
                add("//");
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                begin
                    do b = 8'($urandom_range(1, 255)); while (b == 8'h0A);
                    text.push_back(b);
                end
                text.push_back(8'h0A);
            end
            6: text.push_back(singles[$urandom_range(singles.len() - 1)]);
            7: add(pairs[$urandom_range(8)]);
            default:
            begin
                if ($urandom_range(7) == 0)
                    add("/");
                else
                    text.push_back(leads[$urandom_range(leads.len() - 1)]);
            end
        endcase
        // blank or a single-character token; a dot could glue onto numbers
        if ($urandom_range(3) == 0)
            text.push_back(seps[$urandom_range(seps.len() - 1)]);
        else
            case ($urandom_range(5))
                0: text.push_back(8'h09);
                1: text.push_back(8'h0A);
                2: text.push_back(8'h0B);
                3: text.push_back(8'h0C);
                4: text.push_back(8'h0D);
                default: text.push_back(8'h20);
            endcase
    endtask

    task automatic add_ending();
        case ($urandom_range(3))
            0: text.push_back(8'h00);
            1:
                if ($urandom_range(1))
                    text.push_back(8'($urandom_range(128, 255)));
                else
                    add("@");
            2: add("12.5.");
            default:
            begin
                add("\"open ");
                text.push_back(8'h00);
            end
        endcase
        // ignored after the end word
        for (int i = 0; i < 6; i++)
            text.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (4) @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    initial
    begin
        int total;
        int quarter;
        add("x>>=y>=z<<=<=>\n// note\n\"s\n\"1.5 _9;a->b!");
        while (text.size() < 1850)
            add_fragment();
        add_ending();
        total = text.size();
        quarter = total / 4;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < total; i++)
        begin
            if (i == quarter || i == 2 * quarter || i == 3 * quarter)
            begin
                drain();
                case (i / quarter)
                    1: begin idle_pct = 85; stall_pct = 0; end
                    2: begin idle_pct = 0; stall_pct = 85; end
                    default: begin idle_pct = 8; stall_pct = 8; end
                endcase
            end
            send_word(text[i]);
        end
        drain();
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("source_code_tokenizer: match");
        else
            $display("source_code_tokenizer: mismatch");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("source_code_tokenizer: mismatch");
        $finish;
    end

endmodule

// File: files.f
rtl/core/sct_pkg.sv
rtl/core/sct_front.sv
rtl/core/sct_queue.sv
rtl/core/sct_back.sv
rtl/core/source_code_tokenizer.sv
tb/sct_token_checker.sv
tb/tb_source_code_tokenizer.sv
